// ----- rtl/core/sha1_message_hasher_assert.svh -----
// assertion macros shared by the sha1 message hasher rtl
`ifndef SHA1_MESSAGE_HASHER_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SHA1MH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SHA1MH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sha1mh_pkg.sv -----
// shared types, constants and helpers for the sha1 message hasher
package sha1mh_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FOLD,
    S_EMIT
  } state_t;

  // round group selects f and k
  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } grp_t;

  // control from the sequencer to the datapath modules
  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       load;
    logic       step;
    logic       fold;
    logic       restart;
    grp_t       grp;
  } ctl_t;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [3:0] LenBytes  = 4'd8;
  localparam logic [2:0] LastIdx   = 3'd4;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic word_t round_k(input grp_t g);
    word_t v;
    case (g)
      GRP_CH:   v = 32'h5A827999;
      GRP_PAR1: v = 32'h6ED9EBA1;
      GRP_MAJ:  v = 32'h8F1BBCDC;
      default:  v = 32'hCA62C1D6;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/sha1mh_sched.sv -----
// block buffer and message schedule window, bytes shift in, words shift out
module sha1mh_sched
  import sha1mh_pkg::*;
(
  input  logic  clk,
  input  ctl_t  ctl,
  output word_t w_cur
);

  // word j of the window sits at blk_r[511-32j -: 32], first byte on top
  logic [511:0] blk_r;
  logic [511:0] blk_nxt;
  word_t        w_new;
  word_t        w_mix;

  assign w_cur = blk_r[511:480];
  assign w_mix = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.byte_en) begin
      blk_nxt = {blk_r[503:0], ctl.byte_val};
    end else if (ctl.step) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

// ----- rtl/core/sha1mh_round.sv -----
// shared sha1 round unit with working and chaining registers
module sha1mh_round
  import sha1mh_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  ctl_t            ctl,
  input  word_t           w_cur,
  output word_t [4:0]     chain
);

  word_t [4:0] chain_r;
  word_t [4:0] chain_nxt;
  word_t a_r, b_r, c_r, d_r, e_r;
  word_t a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  word_t f_val;
  word_t t_val;

  assign chain = chain_r;

  always_comb begin
    case (ctl.grp)
      GRP_CH:  f_val = (b_r & c_r) | (~b_r & d_r);
      GRP_MAJ: f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default: f_val = b_r ^ c_r ^ d_r;
    endcase
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + round_k(ctl.grp) + w_cur;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctl.load) begin
      a_nxt = chain_r[0];
      b_nxt = chain_r[1];
      c_nxt = chain_r[2];
      d_nxt = chain_r[3];
      e_nxt = chain_r[4];
    end else if (ctl.step) begin
      a_nxt = t_val;
      b_nxt = a_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      d_nxt = c_r;
      e_nxt = d_r;
    end
  end

  always_comb begin
    chain_nxt = chain_r;
    if (ctl.restart) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = iv_word(3'(i));
      end
    end else if (ctl.fold) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= iv_word(3'(i));
      end
    end else begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

endmodule

// ----- rtl/core/sha1_message_hasher.sv -----
// SHA-1 hasher taking one message byte per input beat. A beat with tuser
// high carries a byte; when it completes a 64-byte block, input is not
// ready while the block runs its 80 rounds on the single round unit and
// then the chaining add. A beat with tlast ends the message, with or
// without a byte: padding then goes in one byte per cycle (9 to 72 bytes),
// costing one or two more compressions, and the digest leaves as five
// output beats, word 0 first, tlast on word 4. Input is not ready from the
// end mark until the last digest beat is taken; after it the hasher is back
// at the initial values. No clearing pass after reset.

`include "sha1_message_hasher_assert.svh"

module sha1_message_hasher
  import sha1mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        out_tlast   // last_word
);

  state_t      state_r, state_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  lenc_r, lenc_nxt;
  logic        mark_r, mark_nxt;
  logic        pad_r, pad_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;

  ctl_t        ctl;
  word_t       w_cur;
  word_t [4:0] chain;
  word_t       dig_word;

  logic        in_acc;
  logic        out_acc;
  logic        absorb;
  logic [63:0] cnt_inc;
  logic        blk_full;
  logic        pad_len;
  logic        msg_done;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign cnt_inc  = cnt_r + 64'd1;
  assign blk_full = (cnt_inc[5:0] == 6'd0);
  // in padding, the length goes out once the zero fill reaches offset 56
  assign pad_len  = mark_r && ((lenc_r != 4'd0) || (cnt_r[5:0] == LenPos));
  assign msg_done = out_acc && (idx_r == LastIdx);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser && blk_full) begin
            state_nxt = S_COMP;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (blk_full) begin
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (rnd_r == RoundLast) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        if (pad_r && (lenc_r == LenBytes)) begin
          state_nxt = S_EMIT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (msg_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_EMIT);
    absorb     = (in_acc && in_tuser) || (state_r == S_PAD);

    ctl          = '0;
    ctl.byte_en  = absorb;
    ctl.byte_val = in_tdata;
    if (state_r == S_PAD) begin
      if (!mark_r) begin
        ctl.byte_val = PadMark;
      end else if (pad_len) begin
        ctl.byte_val = len_r[63:56];
      end else begin
        ctl.byte_val = 8'h00;
      end
    end
    ctl.load    = absorb && blk_full;
    ctl.step    = (state_r == S_COMP);
    ctl.fold    = (state_r == S_FOLD);
    ctl.restart = msg_done;
    if (rnd_r < 7'd20) begin
      ctl.grp = GRP_CH;
    end else if (rnd_r < 7'd40) begin
      ctl.grp = GRP_PAR1;
    end else if (rnd_r < 7'd60) begin
      ctl.grp = GRP_MAJ;
    end else begin
      ctl.grp = GRP_PAR2;
    end

    case (idx_r)
      3'd0:    dig_word = chain[0];
      3'd1:    dig_word = chain[1];
      3'd2:    dig_word = chain[2];
      3'd3:    dig_word = chain[3];
      default: dig_word = chain[4];
    endcase
    out_tdata = {5'd0, idx_r, dig_word};
    out_tlast = (idx_r == LastIdx);
  end

  // sequencer registers
  always_comb begin
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    lenc_nxt = lenc_r;
    mark_nxt = mark_r;
    pad_nxt  = pad_r;
    rnd_nxt  = rnd_r;
    idx_nxt  = idx_r;

    if (absorb) begin
      cnt_nxt = cnt_inc;
    end
    if (in_acc && in_tlast) begin
      // bit length covers the optional byte of this beat
      pad_nxt  = 1'b1;
      mark_nxt = 1'b0;
      lenc_nxt = 4'd0;
      len_nxt  = in_tuser ? {cnt_inc[60:0], 3'd0} : {cnt_r[60:0], 3'd0};
    end
    if (state_r == S_PAD) begin
      if (!mark_r) begin
        mark_nxt = 1'b1;
      end else if (pad_len) begin
        len_nxt  = {len_r[55:0], 8'h00};
        lenc_nxt = lenc_r + 4'd1;
      end
    end
    if (ctl.load) begin
      rnd_nxt = 7'd0;
    end else if (state_r == S_COMP) begin
      rnd_nxt = rnd_r + 7'd1;
    end
    if (state_r == S_FOLD) begin
      idx_nxt = 3'd0;
    end else if (out_acc) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (msg_done) begin
      cnt_nxt = 64'd0;
      pad_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 64'd0;
      lenc_r  <= 4'd0;
      mark_r  <= 1'b0;
      pad_r   <= 1'b0;
      rnd_r   <= 7'd0;
      idx_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      lenc_r  <= lenc_nxt;
      mark_r  <= mark_nxt;
      pad_r   <= pad_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  sha1mh_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .w_cur (w_cur)
  );

  sha1mh_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .w_cur (w_cur),
    .chain (chain)
  );

  `SHA1MH_ASSERT_NOW(a_no_input_while_emit, out_tvalid, !in_tready,
    "input ready while digest is being sent")
  `SHA1MH_ASSERT_NOW(a_comp_on_block_edge, (state_r == S_COMP),
    (cnt_r[5:0] == 6'd0) && (rnd_r <= RoundLast),
    "compression running off a block boundary")
  `SHA1MH_ASSERT_NOW(a_emit_after_length, out_tvalid,
    pad_r && (lenc_r == LenBytes) && (idx_r <= LastIdx),
    "digest sent before length was absorbed")
  `SHA1MH_ASSERT_NEXT(a_restart_after_last, msg_done,
    (state_r == S_IDLE) && (cnt_r == 64'd0) && !pad_r,
    "hasher not restarted after last digest word")

endmodule
